// ===== rtl/core/rrip_bloom_replacement_assert.svh =====
// Assertion macros shared by the replacement policy RTL.
// Each macro expands to one labelled concurrent assertion on a clock with a
// synchronous active-low reset.
`ifndef RRIP_BLOOM_REPLACEMENT_ASSERT_SVH
`define RRIP_BLOOM_REPLACEMENT_ASSERT_SVH

// Same-cycle implication.
`define RRIP_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define RRIP_ASSERT_NXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/rrip_pkg.sv =====
// ----------------------------------------------------------------------------
// rrip_pkg
// Shared constants, divider request/response types and register indexes for
// the RRIP replacement policy with per-set Bloom filter protection.
// ----------------------------------------------------------------------------
package rrip_pkg;

    // Default geometry
    localparam int NUM_SETS_DEF    = 2048;
    localparam int NUM_WAYS_DEF    = 16;
    localparam int BLOOM_WIDTH_DEF = 64;

    // Field widths
    localparam int ADDR_W      = 64;
    localparam int SET_IDX_W   = 11;
    localparam int WAY_IDX_W   = 4;
    localparam int TAG_W       = 16;
    localparam int TAG_LSB     = 12;
    localparam int RRPV_W      = 2;
    localparam int COUNT_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // RRPV values
    localparam logic [RRPV_W-1:0] RRPV_MAX = 2'd3;
    localparam logic [RRPV_W-1:0] RRPV_MID = 2'd2;
    localparam logic [RRPV_W-1:0] RRPV_LOW = 2'd1;
    localparam logic [RRPV_W-1:0] RRPV_HIT = 2'd0;

    // Register reset values and indexes
    localparam logic [RRPV_W-1:0]     INSERT_RRPV_RST = 2'd2;
    localparam logic [COUNT_W-1:0]    CLEAR_MASK_RST  = 16'h1FFF;
    localparam logic [CFG_INDEX_W-1:0] REG_INSERT_RRPV = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_MASK  = 2'd1;

    // Opcodes
    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Second hash divisor
    localparam int HASH_DIV = 17;

    // Constant divider: q = (x * floor(2^SHIFT / d)) >> SHIFT, then one fix-up
    localparam int DIV_X_W   = 16;
    localparam int DIV_D_W   = 17;
    localparam int DIV_R_W   = 17;
    localparam int DIV_SHIFT = 16;
    localparam int DIV_ONE   = 1 << DIV_SHIFT;
    localparam int DIV_P_W   = DIV_X_W + DIV_R_W;

    typedef enum logic [1:0] {
        DIV_SET   = 2'd0,
        DIV_HASH  = 2'd1,
        DIV_BLOOM = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic               start;
        div_sel_t           sel;
        logic [DIV_X_W-1:0] x;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_X_W-1:0] q;
        logic [DIV_D_W-1:0] r;
    } div_rsp_t;

endpackage

// ===== rtl/core/rrip_ram.sv =====
// ----------------------------------------------------------------------------
// rrip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/rrip_cdiv.sv =====
// ----------------------------------------------------------------------------
// rrip_cdiv
// Shared divider by one of three constants (set count, hash divisor,
// filter width): reciprocal multiply, back-multiply, one fix-up.
// ----------------------------------------------------------------------------
`include "rrip_bloom_replacement_assert.svh"

module rrip_cdiv #(
    parameter int NUM_SETS    = rrip_pkg::NUM_SETS_DEF,
    parameter int BLOOM_WIDTH = rrip_pkg::BLOOM_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rrip_pkg::div_req_t req,
    output rrip_pkg::div_rsp_t rsp
);

    localparam int XW = rrip_pkg::DIV_X_W;
    localparam int DW = rrip_pkg::DIV_D_W;
    localparam int RW = rrip_pkg::DIV_R_W;
    localparam int PW = rrip_pkg::DIV_P_W;

    localparam logic [RW-1:0] RECIP_SET   = RW'(rrip_pkg::DIV_ONE / NUM_SETS);
    localparam logic [RW-1:0] RECIP_HASH  = RW'(rrip_pkg::DIV_ONE / rrip_pkg::HASH_DIV);
    localparam logic [RW-1:0] RECIP_BLOOM = RW'(rrip_pkg::DIV_ONE / BLOOM_WIDTH);
    localparam logic [DW-1:0] DIVR_SET    = DW'(NUM_SETS);
    localparam logic [DW-1:0] DIVR_HASH   = DW'(rrip_pkg::HASH_DIV);
    localparam logic [DW-1:0] DIVR_BLOOM  = DW'(BLOOM_WIDTH);

    logic [RW-1:0] recip_sel;
    logic [DW-1:0] divr_sel;

    logic          v1_reg;
    logic [PW-1:0] prod_reg;
    logic [XW-1:0] x1_reg;
    logic [DW-1:0] d1_reg;

    logic          v2_reg;
    logic [XW-1:0] q2_reg;
    logic [DW:0]   r2_reg;
    logic [DW-1:0] d2_reg;

    logic          v3_reg;
    logic [XW-1:0] q3_reg;
    logic [DW-1:0] r3_reg;

    logic [XW-1:0]    q_est;
    logic [XW+DW-1:0] qd;
    logic [XW+DW-1:0] rem_full;

    always_comb begin
        unique case (req.sel)
            rrip_pkg::DIV_SET: begin
                recip_sel = RECIP_SET;
                divr_sel  = DIVR_SET;
            end
            rrip_pkg::DIV_HASH: begin
                recip_sel = RECIP_HASH;
                divr_sel  = DIVR_HASH;
            end
            rrip_pkg::DIV_BLOOM: begin
                recip_sel = RECIP_BLOOM;
                divr_sel  = DIVR_BLOOM;
            end
            default: begin
                recip_sel = RECIP_BLOOM;
                divr_sel  = DIVR_BLOOM;
            end
        endcase
    end

    // Estimate is exact or one short
    assign q_est    = prod_reg[rrip_pkg::DIV_SHIFT +: XW];
    assign qd       = q_est * d1_reg;
    assign rem_full = {DW'(0), x1_reg} - qd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= req.x * recip_sel;
        x1_reg   <= req.x;
        d1_reg   <= divr_sel;
        q2_reg   <= q_est;
        r2_reg   <= rem_full[DW:0];
        d2_reg   <= d1_reg;
        if (r2_reg >= {1'b0, d2_reg}) begin
            q3_reg <= q2_reg + 1'b1;
            r3_reg <= DW'(r2_reg - {1'b0, d2_reg});
        end else begin
            q3_reg <= q2_reg;
            r3_reg <= r2_reg[DW-1:0];
        end
    end

    assign rsp = '{done: v3_reg, q: q3_reg, r: r3_reg};

    `RRIP_ASSERT_IMP(a_cdiv_rem_bound, aclk, aresetn, v2_reg, (r2_reg < {d2_reg, 1'b0}), "reciprocal estimate off by more than one")

endmodule

// ===== rtl/core/rrip_row.sv =====
// ----------------------------------------------------------------------------
// rrip_row
// Set row logic: victim selection with filter protection and aging, and the
// row contents after an update (RRPV, stored hash positions, filter).
// ----------------------------------------------------------------------------
module rrip_row #(
    parameter int NUM_WAYS    = rrip_pkg::NUM_WAYS_DEF,
    parameter int BLOOM_WIDTH = rrip_pkg::BLOOM_WIDTH_DEF,
    localparam int WAY_W      = $clog2(NUM_WAYS),
    localparam int POS_W      = $clog2(BLOOM_WIDTH),
    localparam int VW         = (WAY_W > rrip_pkg::WAY_IDX_W) ? WAY_W : rrip_pkg::WAY_IDX_W
) (
    input  logic                                         opcode,
    input  logic [rrip_pkg::WAY_IDX_W-1:0]               way_index,
    input  logic                                         hit,
    input  logic [rrip_pkg::RRPV_W-1:0]                  insert_rrpv,
    input  logic                                         clear_filter,
    input  logic [POS_W-1:0]                             pos0,
    input  logic [POS_W-1:0]                             pos1,
    input  logic [NUM_WAYS-1:0][rrip_pkg::RRPV_W-1:0]    rrpv_row,
    input  logic [NUM_WAYS-1:0][1:0][POS_W-1:0]          pos_row,
    input  logic [BLOOM_WIDTH-1:0]                       bloom_row,
    output logic [NUM_WAYS-1:0][rrip_pkg::RRPV_W-1:0]    rrpv_next,
    output logic [NUM_WAYS-1:0][1:0][POS_W-1:0]          pos_next,
    output logic [BLOOM_WIDTH-1:0]                       bloom_next,
    output logic                                         way_in_range,
    output logic [rrip_pkg::WAY_IDX_W-1:0]               victim_way
);

    logic [NUM_WAYS-1:0]               is3;
    logic [NUM_WAYS-1:0]               is2;
    logic [NUM_WAYS-1:0]               is1;
    logic [NUM_WAYS-1:0]               at_max;
    logic [NUM_WAYS-1:0]               fresh;
    logic [NUM_WAYS-1:0]               pick;
    logic [rrip_pkg::RRPV_W-1:0]       maxv;
    logic [rrip_pkg::RRPV_W-1:0]       age_inc;
    logic [rrip_pkg::RRPV_W-1:0]       fill;
    logic [WAY_W-1:0]                  way_sel;
    logic [VW-1:0]                     victim_full;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            is3[w]   = (rrpv_row[w] == rrip_pkg::RRPV_MAX);
            is2[w]   = (rrpv_row[w] == rrip_pkg::RRPV_MID);
            is1[w]   = (rrpv_row[w] == rrip_pkg::RRPV_LOW);
            fresh[w] = is3[w] & ~(bloom_row[pos_row[w][0]] & bloom_row[pos_row[w][1]]);
        end

        priority if (|is3) begin
            maxv = rrip_pkg::RRPV_MAX;
        end else if (|is2) begin
            maxv = rrip_pkg::RRPV_MID;
        end else if (|is1) begin
            maxv = rrip_pkg::RRPV_LOW;
        end else begin
            maxv = rrip_pkg::RRPV_HIT;
        end
        age_inc = rrip_pkg::RRPV_MAX - maxv;

        for (int w = 0; w < NUM_WAYS; w++) begin
            at_max[w] = (rrpv_row[w] == maxv);
        end

        // Unprotected distant ways first, then any way that reaches the top
        pick = (|fresh) ? fresh : at_max;
        victim_full = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (pick[w]) begin
                victim_full = VW'(w);
            end
        end
        victim_way = victim_full[rrip_pkg::WAY_IDX_W-1:0];
    end

    assign way_sel      = WAY_W'(way_index);
    assign way_in_range = (int'(way_index) < NUM_WAYS);
    assign fill         = hit ? rrip_pkg::RRPV_HIT : insert_rrpv;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (opcode == rrip_pkg::OP_VICTIM) begin
                rrpv_next[w] = rrpv_row[w] + age_inc;
                pos_next[w]  = pos_row[w];
            end else if (way_sel == WAY_W'(w)) begin
                rrpv_next[w]   = fill;
                pos_next[w][0] = pos0;
                pos_next[w][1] = pos1;
            end else begin
                rrpv_next[w] = rrpv_row[w];
                pos_next[w]  = pos_row[w];
            end
        end
        for (int b = 0; b < BLOOM_WIDTH; b++) begin
            bloom_next[b] = ~clear_filter &
                            (bloom_row[b] | (POS_W'(b) == pos0) | (POS_W'(b) == pos1));
        end
    end

endmodule

// ===== rtl/core/rrip_bloom_replacement.sv =====
// ----------------------------------------------------------------------------
// rrip_bloom_replacement
// 2-bit SRRIP replacement policy with per-set Bloom filter protection.
//
// Input channel (s_*): one policy operation per beat. Opcode 0 asks for a
// victim way in the set; opcode 1 records an access (hit or fill) to a way.
// Result channel (m_*): exactly one beat per operation, in order, carrying
// the victim way (find victim) or the filter-cleared flag (update).
// Config channel (cfg_*): index 0 sets the fill RRPV, index 1 the filter
// clear mask; always ready, write only while no operation is in flight.
// Sequencing: one operation at a time; s_ready stays low from acceptance
// until the output register is loaded. Each operation uses the shared
// constant divider once for the set wrap and, on an update, three times
// more for the tag hash positions, then writes the set row and loads the
// result register.
// Set rows live in three RAMs.
// Reset: a clearing pass writes every set row with s_ready low. A stalled
// result holds in the output register; the next operation is still taken
// and runs, then waits with s_ready low until that beat is taken.
// ----------------------------------------------------------------------------
`include "rrip_bloom_replacement_assert.svh"

module rrip_bloom_replacement #(
    parameter int NUM_SETS    = rrip_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS    = rrip_pkg::NUM_WAYS_DEF,
    parameter int BLOOM_WIDTH = rrip_pkg::BLOOM_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic [rrip_pkg::SET_IDX_W-1:0]      s_set_index,
    input  logic [rrip_pkg::WAY_IDX_W-1:0]      s_way_index,
    input  logic [rrip_pkg::ADDR_W-1:0]         s_address,
    input  logic                                s_hit,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rrip_pkg::WAY_IDX_W-1:0]      m_victim_way,
    output logic                                m_filter_cleared,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rrip_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rrip_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SET_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int POS_W      = $clog2(BLOOM_WIDTH);
    localparam int RRPV_ROW_W = NUM_WAYS * rrip_pkg::RRPV_W;
    localparam int POS_ROW_W  = NUM_WAYS * 2 * POS_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SET,
        S_TAGQ,
        S_POS0,
        S_POS1,
        S_WRITE,
        S_OUT
    } state_t;

    state_t                              state_reg;
    logic [SET_W-1:0]                    clr_addr_reg;
    logic [rrip_pkg::COUNT_W-1:0]        count_reg;
    logic [rrip_pkg::RRPV_W-1:0]         insert_rrpv_reg;
    logic [rrip_pkg::COUNT_W-1:0]        clear_mask_reg;
    logic                                op_reg;
    logic [rrip_pkg::WAY_IDX_W-1:0]      way_reg;
    logic                                hit_reg;
    logic [rrip_pkg::TAG_W-1:0]          tag_reg;
    logic [SET_W-1:0]                    set_reg;
    logic [rrip_pkg::DIV_X_W-1:0]        q17_reg;
    logic [POS_W-1:0]                    p0_reg;
    logic [POS_W-1:0]                    p1_reg;
    logic [rrip_pkg::WAY_IDX_W-1:0]      res_victim_reg;
    logic                                res_cleared_reg;
    logic                                m_valid_reg;
    logic [rrip_pkg::WAY_IDX_W-1:0]      m_victim_reg;
    logic                                m_cleared_reg;
    rrip_pkg::div_req_t                  div_req_reg;
    rrip_pkg::div_rsp_t                  div_rsp;

    logic                                clear_now;
    logic                                rd_en;
    logic [SET_W-1:0]                    rd_addr;
    logic [SET_W-1:0]                    wr_addr;
    logic                                rrpv_we;
    logic                                pos_we;
    logic                                bloom_we;
    logic [RRPV_ROW_W-1:0]               rrpv_wdata;
    logic [POS_ROW_W-1:0]                pos_wdata;
    logic [BLOOM_WIDTH-1:0]              bloom_wdata;
    logic [RRPV_ROW_W-1:0]               rrpv_rdata;
    logic [POS_ROW_W-1:0]                pos_rdata;
    logic [BLOOM_WIDTH-1:0]              bloom_rdata;
    logic [RRPV_ROW_W-1:0]               rrpv_upd;
    logic [POS_ROW_W-1:0]                pos_upd;
    logic [BLOOM_WIDTH-1:0]              bloom_upd;
    logic                                way_in_range;
    logic [rrip_pkg::WAY_IDX_W-1:0]      row_victim;

    assign clear_now = ((count_reg & clear_mask_reg) == '0);

    rrip_cdiv #(
        .NUM_SETS    (NUM_SETS),
        .BLOOM_WIDTH (BLOOM_WIDTH)
    ) u_cdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

    rrip_row #(
        .NUM_WAYS    (NUM_WAYS),
        .BLOOM_WIDTH (BLOOM_WIDTH)
    ) u_row (
        .opcode       (op_reg),
        .way_index    (way_reg),
        .hit          (hit_reg),
        .insert_rrpv  (insert_rrpv_reg),
        .clear_filter (clear_now),
        .pos0         (p0_reg),
        .pos1         (p1_reg),
        .rrpv_row     (rrpv_rdata),
        .pos_row      (pos_rdata),
        .bloom_row    (bloom_rdata),
        .rrpv_next    (rrpv_upd),
        .pos_next     (pos_upd),
        .bloom_next   (bloom_upd),
        .way_in_range (way_in_range),
        .victim_way   (row_victim)
    );

    always_comb begin
        rd_en   = (state_reg == S_SET) && div_rsp.done;
        rd_addr = div_rsp.r[SET_W-1:0];
        if (state_reg == S_CLEAR) begin
            // Reset image: every way distant, no tag hashes, empty filter
            wr_addr     = clr_addr_reg;
            rrpv_we     = 1'b1;
            pos_we      = 1'b1;
            bloom_we    = 1'b1;
            rrpv_wdata  = '1;
            pos_wdata   = '0;
            bloom_wdata = '0;
        end else begin
            wr_addr     = set_reg;
            rrpv_we     = (state_reg == S_WRITE) &&
                          ((op_reg == rrip_pkg::OP_VICTIM) || way_in_range);
            pos_we      = (state_reg == S_WRITE) && (op_reg == rrip_pkg::OP_UPDATE) &&
                          way_in_range;
            bloom_we    = (state_reg == S_WRITE) && (op_reg == rrip_pkg::OP_UPDATE);
            rrpv_wdata  = rrpv_upd;
            pos_wdata   = pos_upd;
            bloom_wdata = bloom_upd;
        end
    end

    rrip_ram #(.WIDTH(RRPV_ROW_W), .DEPTH(NUM_SETS)) u_rrpv_ram (
        .aclk    (aclk),
        .wr_en   (rrpv_we),
        .wr_addr (wr_addr),
        .wr_data (rrpv_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rrpv_rdata)
    );

    rrip_ram #(.WIDTH(POS_ROW_W), .DEPTH(NUM_SETS)) u_pos_ram (
        .aclk    (aclk),
        .wr_en   (pos_we),
        .wr_addr (wr_addr),
        .wr_data (pos_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (pos_rdata)
    );

    rrip_ram #(.WIDTH(BLOOM_WIDTH), .DEPTH(NUM_SETS)) u_bloom_ram (
        .aclk    (aclk),
        .wr_en   (bloom_we),
        .wr_addr (wr_addr),
        .wr_data (bloom_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (bloom_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_CLEAR;
            clr_addr_reg      <= '0;
            count_reg         <= '0;
            insert_rrpv_reg   <= rrip_pkg::INSERT_RRPV_RST;
            clear_mask_reg    <= rrip_pkg::CLEAR_MASK_RST;
            m_valid_reg       <= 1'b0;
            div_req_reg.start <= 1'b0;
        end else begin
            // The output state reloads the register itself
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rrip_pkg::REG_INSERT_RRPV: insert_rrpv_reg <= cfg_data[rrip_pkg::RRPV_W-1:0];
                    rrip_pkg::REG_CLEAR_MASK:  clear_mask_reg  <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == SET_W'(NUM_SETS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg      <= s_opcode;
                        way_reg     <= s_way_index;
                        hit_reg     <= s_hit;
                        tag_reg     <= s_address[rrip_pkg::TAG_LSB +: rrip_pkg::TAG_W];
                        count_reg   <= count_reg + 1'b1;
                        div_req_reg <= '{start: 1'b1, sel: rrip_pkg::DIV_SET,
                                         x: rrip_pkg::DIV_X_W'(s_set_index)};
                        state_reg   <= S_SET;
                    end
                end
                S_SET: begin
                    if (div_rsp.done) begin
                        set_reg <= div_rsp.r[SET_W-1:0];
                        if (op_reg == rrip_pkg::OP_UPDATE) begin
                            div_req_reg <= '{start: 1'b1, sel: rrip_pkg::DIV_HASH,
                                             x: tag_reg};
                            state_reg   <= S_TAGQ;
                        end else begin
                            state_reg <= S_WRITE;
                        end
                    end else begin
                        div_req_reg.start <= 1'b0;
                    end
                end
                S_TAGQ: begin
                    if (div_rsp.done) begin
                        q17_reg     <= div_rsp.q;
                        div_req_reg <= '{start: 1'b1, sel: rrip_pkg::DIV_BLOOM, x: tag_reg};
                        state_reg   <= S_POS0;
                    end else begin
                        div_req_reg.start <= 1'b0;
                    end
                end
                S_POS0: begin
                    if (div_rsp.done) begin
                        p0_reg      <= div_rsp.r[POS_W-1:0];
                        div_req_reg <= '{start: 1'b1, sel: rrip_pkg::DIV_BLOOM, x: q17_reg};
                        state_reg   <= S_POS1;
                    end else begin
                        div_req_reg.start <= 1'b0;
                    end
                end
                S_POS1: begin
                    if (div_rsp.done) begin
                        p1_reg    <= div_rsp.r[POS_W-1:0];
                        state_reg <= S_WRITE;
                    end else begin
                        div_req_reg.start <= 1'b0;
                    end
                end
                S_WRITE: begin
                    res_victim_reg  <= (op_reg == rrip_pkg::OP_VICTIM) ? row_victim : '0;
                    res_cleared_reg <= (op_reg == rrip_pkg::OP_UPDATE) && clear_now;
                    state_reg       <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the previous beat has gone
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_victim_reg  <= res_victim_reg;
                        m_cleared_reg <= res_cleared_reg;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_victim_way     = m_victim_reg;
    assign m_filter_cleared = m_cleared_reg;

    `RRIP_ASSERT_IMP(a_div_done_waiting, aclk, aresetn, div_rsp.done, (state_reg == S_SET || state_reg == S_TAGQ || state_reg == S_POS0 || state_reg == S_POS1), "divider result with no operation waiting")
    `RRIP_ASSERT_NXT(a_accept_starts_set, aclk, aresetn, (s_valid && s_ready), (div_req_reg.start && div_req_reg.sel == rrip_pkg::DIV_SET), "accepted beat did not start set wrap")
    `RRIP_ASSERT_IMP(a_set_in_range, aclk, aresetn, (state_reg == S_SET && div_rsp.done), (32'(div_rsp.r) < NUM_SETS), "wrapped set index out of range")

endmodule

// ===== bench/rrip_bloom_replacement_checker.sv =====
// ----------------------------------------------------------------------------
// rrip_bloom_replacement_checker
// Watches the operation, result and register channels of the replacement
// policy, keeps its own copy of the per-way RRPVs, page tags, per-set Bloom
// filters and operation counter, and checks every result beat in order against
// the victim way or filter-cleared flag that copy predicts.
// ----------------------------------------------------------------------------
module rrip_bloom_replacement_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [rrip_pkg::SET_IDX_W-1:0]   s_set_index,
    input  logic [rrip_pkg::WAY_IDX_W-1:0]   s_way_index,
    input  logic [rrip_pkg::ADDR_W-1:0]      s_address,
    input  logic                             s_hit,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [rrip_pkg::WAY_IDX_W-1:0]   m_victim_way,
    input  logic                             m_filter_cleared,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [rrip_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rrip_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatch_count,
    output int                               results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSETS = rrip_pkg::NUM_SETS_DEF;
    localparam int NWAYS = rrip_pkg::NUM_WAYS_DEF;
    localparam int BLOOM = rrip_pkg::BLOOM_WIDTH_DEF;
    localparam int SLOTS = NSETS * NWAYS;
    localparam int WAY_W = rrip_pkg::WAY_IDX_W;

    typedef struct packed {
        logic [rrip_pkg::WAY_IDX_W-1:0] victim_way;
        logic                           filter_cleared;
    } policy_result_t;

    logic [rrip_pkg::RRPV_W-1:0]  way_rrpv [SLOTS];
    logic [rrip_pkg::TAG_W-1:0]   way_tag  [SLOTS];
    logic [BLOOM-1:0]             set_filter [NSETS];
    logic [rrip_pkg::COUNT_W-1:0] op_count;
    logic [rrip_pkg::RRPV_W-1:0]  fill_rrpv;
    logic [rrip_pkg::COUNT_W-1:0] filter_clear_mask;
    policy_result_t               owed_results [$];

    initial mismatch_count = 0;
    initial results_owed = 0;

    function automatic logic [BLOOM-1:0] tag_filter_bits(logic [rrip_pkg::TAG_W-1:0] tag);
        int unsigned pos_lo;
        int unsigned pos_hi;
        pos_lo = tag % BLOOM;
        pos_hi = (tag / rrip_pkg::HASH_DIV) % BLOOM;
        return (BLOOM'(1) << pos_lo) | (BLOOM'(1) << pos_hi);
    endfunction

    function automatic bit filter_holds(logic [BLOOM-1:0] filter,
                                        logic [rrip_pkg::TAG_W-1:0] tag);
        logic [BLOOM-1:0] bits;
        bits = tag_filter_bits(tag);
        return (filter & bits) == bits;
    endfunction

    // Victim search; ages the whole set when no way sits at the distant RRPV.
    function automatic logic [WAY_W-1:0] predict_victim(int unsigned set_row);
        int unsigned base;
        logic [rrip_pkg::RRPV_W-1:0] oldest;
        base = set_row * NWAYS;
        oldest = rrip_pkg::RRPV_HIT;
        for (int w = 0; w < NWAYS; w++)
            if (way_rrpv[base + w] == rrip_pkg::RRPV_MAX &&
                !filter_holds(set_filter[set_row], way_tag[base + w]))
                return WAY_W'(w);
        for (int w = 0; w < NWAYS; w++)
            if (way_rrpv[base + w] == rrip_pkg::RRPV_MAX)
                return WAY_W'(w);
        for (int w = 0; w < NWAYS; w++)
            if (way_rrpv[base + w] > oldest)
                oldest = way_rrpv[base + w];
        for (int w = 0; w < NWAYS; w++)
            way_rrpv[base + w] = way_rrpv[base + w] + (rrip_pkg::RRPV_MAX - oldest);
        for (int w = 0; w < NWAYS; w++)
            if (way_rrpv[base + w] == rrip_pkg::RRPV_MAX)
                return WAY_W'(w);
        return '0;
    endfunction

    always @(posedge aclk) begin
        policy_result_t due;
        int unsigned set_row;
        int unsigned slot;
        logic [rrip_pkg::TAG_W-1:0] tag;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                way_rrpv[i] = rrip_pkg::RRPV_MAX;
                way_tag[i] = '0;
            end
            for (int i = 0; i < NSETS; i++)
                set_filter[i] = '0;
            op_count = '0;
            fill_rrpv = rrip_pkg::INSERT_RRPV_RST;
            filter_clear_mask = rrip_pkg::CLEAR_MASK_RST;
            owed_results.delete();
        end else begin
            // Results first: a beat taken here belongs to an earlier operation.
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result beat with nothing owed: expected none, %s %0d %0b",
                             $time, "got victim_way/filter_cleared",
                             m_victim_way, m_filter_cleared);
                    mismatch_count++;
                end else begin
                    due = owed_results.pop_front();
                    if (m_victim_way !== due.victim_way) begin
                        $display("%0t: victim_way expected %0d got %0d",
                                 $time, due.victim_way, m_victim_way);
                        mismatch_count++;
                    end
                    if (m_filter_cleared !== due.filter_cleared) begin
                        $display("%0t: filter_cleared expected %0b got %0b",
                                 $time, due.filter_cleared, m_filter_cleared);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rrip_pkg::REG_INSERT_RRPV:
                        fill_rrpv = cfg_data[rrip_pkg::RRPV_W-1:0];
                    rrip_pkg::REG_CLEAR_MASK:
                        filter_clear_mask = cfg_data[rrip_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                set_row = s_set_index % NSETS;
                tag = s_address[rrip_pkg::TAG_LSB +: rrip_pkg::TAG_W];
                op_count = op_count + 1'b1;
                due = '0;
                if (s_opcode == rrip_pkg::OP_VICTIM) begin
                    due.victim_way = predict_victim(set_row);
                end else begin
                    if (s_way_index < NWAYS) begin
                        slot = set_row * NWAYS + s_way_index;
                        way_rrpv[slot] = s_hit ? rrip_pkg::RRPV_HIT : fill_rrpv;
                        way_tag[slot] = tag;
                    end
                    set_filter[set_row] = set_filter[set_row] | tag_filter_bits(tag);
                    if ((op_count & filter_clear_mask) == '0) begin
                        set_filter[set_row] = '0;
                        due.filter_cleared = 1'b1;
                    end
                end
                owed_results.push_back(due);
            end
        end
        results_owed <= owed_results.size();
    end

endmodule

// ===== bench/tb_rrip_bloom_replacement.sv =====
// ----------------------------------------------------------------------------
// tb_rrip_bloom_replacement
// Drives victim searches and access updates into the replacement policy in
// bursts, stalls the result channel on a shifting pattern, and steps through
// several fill-RRPV and filter-clear settings. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rrip_bloom_replacement;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT     = 20000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_PER_SET = 150;
    localparam int PHASES         = 5;
    localparam int SET_W          = rrip_pkg::SET_IDX_W;
    localparam int WAY_W          = rrip_pkg::WAY_IDX_W;
    localparam int ADDR_W         = rrip_pkg::ADDR_W;
    localparam int TAG_W          = rrip_pkg::TAG_W;
    localparam int TAG_LSB        = rrip_pkg::TAG_LSB;

    logic                                aclk;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic                                s_opcode = rrip_pkg::OP_VICTIM;
    logic [SET_W-1:0]                    s_set_index = '0;
    logic [WAY_W-1:0]                    s_way_index = '0;
    logic [ADDR_W-1:0]                   s_address = '0;
    logic                                s_hit = 1'b0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [WAY_W-1:0]                    m_victim_way;
    logic                                m_filter_cleared;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [rrip_pkg::CFG_INDEX_W-1:0]    cfg_index = rrip_pkg::REG_INSERT_RRPV;
    logic [rrip_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    int mismatch_count;
    int results_owed;
    int burst_left = 1;
    int idle_cycles = 0;

    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age = 0;
    int          ready_phase = 0;

    logic [rrip_pkg::RRPV_W-1:0]  phase_fill [PHASES] = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3};
    logic [rrip_pkg::COUNT_W-1:0] phase_mask [PHASES] =
        '{16'h0000, 16'h0003, 16'hFFFF, 16'h0010, 16'h1FFF};

    rrip_bloom_replacement i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_set_index      (s_set_index),
        .s_way_index      (s_way_index),
        .s_address        (s_address),
        .s_hit            (s_hit),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_victim_way     (m_victim_way),
        .m_filter_cleared (m_filter_cleared),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    rrip_bloom_replacement_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_set_index      (s_set_index),
        .s_way_index      (s_way_index),
        .s_address        (s_address),
        .s_hit            (s_hit),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_victim_way     (m_victim_way),
        .m_filter_cleared (m_filter_cleared),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .results_owed     (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result-side back-pressure: a 16-bit ready pattern, swapped every so often.
    always @(posedge aclk) begin
        if (pattern_age == 0) begin
            case ($urandom_range(0, 2))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'($urandom) | 16'h0001;
                default: ready_pattern = 16'h0001 << $urandom_range(0, 15);
            endcase
            pattern_age = $urandom_range(32, 256);
        end else begin
            pattern_age--;
        end
        ready_phase = (ready_phase + 1) % 16;
        m_ready <= ready_pattern[ready_phase];
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("rrip_bloom_replacement verification failed");
            $finish;
        end
    end

    // One operation beat, then burst bookkeeping: hold valid inside a burst,
    // and between bursts mostly drop it for a random gap.
    task automatic push_op(input logic op, input logic [SET_W-1:0] set_idx,
                           input logic [WAY_W-1:0] way, input logic [ADDR_W-1:0] addr,
                           input logic hit);
        int gap;
        s_valid <= 1'b1;
        s_opcode <= op;
        s_set_index <= set_idx;
        s_way_index <= way;
        s_address <= addr;
        s_hit <= hit;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 48)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic drain;
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_policy(input logic [rrip_pkg::RRPV_W-1:0] fill,
                              input logic [rrip_pkg::COUNT_W-1:0] mask);
        cfg_valid <= 1'b1;
        cfg_index <= rrip_pkg::REG_INSERT_RRPV;
        cfg_data <= rrip_pkg::CFG_DATA_W'(fill);
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= rrip_pkg::REG_CLEAR_MASK;
        cfg_data <= mask;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a handful of hot sets and page tags so RRPVs age and filters fill;
    // the rest is spread over the whole index and address space.
    task automatic run_random(input int count);
        logic [SET_W-1:0]  hot_sets [4];
        logic [TAG_W-1:0]  hot_tags [8];
        logic [SET_W-1:0]  set_idx;
        logic [ADDR_W-1:0] addr;
        logic              op;
        foreach (hot_sets[i])
            hot_sets[i] = SET_W'($urandom);
        hot_sets[0] = ($urandom_range(0, 1) == 0) ? '0 : '1;
        foreach (hot_tags[i])
            hot_tags[i] = ($urandom_range(0, 1) == 0) ? TAG_W'($urandom_range(0, 255))
                                                      : TAG_W'($urandom);
        for (int n = 0; n < count; n++) begin
            set_idx = ($urandom_range(0, 19) < 17) ? hot_sets[$urandom_range(0, 3)]
                                                   : SET_W'($urandom);
            addr = {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0)
                addr[TAG_LSB +: TAG_W] = hot_tags[$urandom_range(0, 7)];
            op = ($urandom_range(0, 9) < 4) ? rrip_pkg::OP_VICTIM : rrip_pkg::OP_UPDATE;
            push_op(op, set_idx, WAY_W'($urandom), addr, 1'($urandom));
            if (n % 100 == 99)
                drain();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // Hold until the clearing pass after reset is over.
        do @(posedge aclk); while (!s_ready);

        // Reset settings: empty set takes way 0, then filing tag 0 protects every
        // distant way and forces the plain first-distant fallback.
        push_op(rrip_pkg::OP_VICTIM, '0, '1, '0, 1'b1);
        push_op(rrip_pkg::OP_UPDATE, '0, '0, '0, 1'b0);
        push_op(rrip_pkg::OP_VICTIM, '0, '0, '0, 1'b0);
        // Fill the last set with near RRPVs but the last way; search twice, aging once.
        for (int w = 0; w < rrip_pkg::NUM_WAYS_DEF; w++)
            push_op(rrip_pkg::OP_UPDATE, '1, WAY_W'(w),
                    (w == 0) ? '1 : ADDR_W'({$urandom, $urandom}),
                    (w != rrip_pkg::NUM_WAYS_DEF - 1));
        push_op(rrip_pkg::OP_VICTIM, '1, '0, '1, 1'b0);
        push_op(rrip_pkg::OP_VICTIM, '1, '1, '0, 1'b1);
        run_random(RANDOM_PER_SET);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            set_policy(phase_fill[p], phase_mask[p]);
            run_random(RANDOM_PER_SET);
            drain();
        end

        if (mismatch_count == 0 && results_owed == 0)
            $display("rrip_bloom_replacement verification clean");
        else
            $display("rrip_bloom_replacement verification failed");
        $finish;
    end

endmodule
